/* src/fwnf_pkg.sv */
package fwnf_pkg;

  localparam int DecDigits   = 10;
  localparam int HexDigits   = 8;
  localparam int MaxWidthDef = 16;
  localparam int FifoDepth   = 2;

  localparam logic [7:0]  PadSpace  = 8'h20;
  localparam logic [7:0]  CharZero  = 8'h30;
  localparam logic [7:0]  CharAlpha = 8'h41;
  localparam logic [3:0]  Radix     = 4'd10;
  localparam logic [3:0]  NibMask   = 4'hf;
  // Reciprocal of ten scaled by 2^35; exact for every 32-bit dividend.
  localparam logic [31:0] RecipTen  = 32'hcccc_cccd;
  localparam int          RecipSh   = 35;

  typedef enum logic {
    KIND_DEC = 1'b0,
    KIND_HEX = 1'b1
  } kind_e;

  typedef struct packed {
    logic [DecDigits-1:0][3:0] dig;
    logic [3:0]                nsig;
    logic [4:0]                width;
    logic [7:0]                pad;
  } rec_t;

  function automatic logic [7:0] glyph(input logic [3:0] d);
    logic [7:0] c;
    if (d < Radix) begin
      c = CharZero + {4'd0, d};
    end else begin
      c = CharAlpha + {4'd0, d - Radix};
    end
    return c;
  endfunction

  function automatic logic [3:0] hex_nsig(input logic [31:0] v);
    logic [3:0] n;
    n = 4'd0;
    for (int i = 0; i < HexDigits; i++) begin
      if ((v[i*4 +: 4] & NibMask) != 4'd0) begin
        n = 4'(i + 1);
      end
    end
    return n;
  endfunction

endpackage

/* src/fwnf_if.sv */
interface fwnf_in_if;
  logic        valid;
  logic        ready;
  logic        kind;
  logic [31:0] value;
  logic [4:0]  width;
  logic [7:0]  pad_char;

  modport source (output valid, kind, value, width, pad_char, input ready);
  modport sink   (input valid, kind, value, width, pad_char, output ready);
endinterface

interface fwnf_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] ch;
  logic       last;

  modport source (output valid, ch, last, input ready);
  modport sink   (input valid, ch, last, output ready);
endinterface

/* src/fwnf_front.sv */
module fwnf_front import fwnf_pkg::*; #(
  parameter int MAX_WIDTH = MaxWidthDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  fwnf_in_if.sink     in_i,
  output rec_t        rec_o,
  output logic        rec_valid_o,
  input  logic        rec_ready_i,
  output logic        busy_o
);

  logic        busy_q, busy_d;
  logic        done_q, done_d;
  logic [31:0] val_q, val_d;
  logic [3:0]  cnt_q, cnt_d;
  rec_t        rec_q, rec_d;

  logic        push, acc;
  logic [63:0] prod;
  logic [28:0] quo;
  logic [31:0] quo_x10;
  logic [3:0]  rem;

  assign push        = busy_q && done_q && rec_ready_i;
  assign in_i.ready  = !busy_q || push;
  assign acc         = in_i.valid && in_i.ready;
  assign rec_valid_o = busy_q && done_q;
  assign rec_o       = rec_q;
  assign busy_o      = busy_q;

  // One decimal digit per cycle: quotient by reciprocal, remainder by back-multiply.
  assign prod    = 64'(val_q) * 64'(RecipTen);
  assign quo     = prod[63:RecipSh];
  assign quo_x10 = {quo, 3'b000} + {2'b00, quo, 1'b0};
  assign rem     = 4'(val_q - quo_x10);

  always_comb begin
    busy_d = busy_q;
    done_d = done_q;
    val_d  = val_q;
    cnt_d  = cnt_q;
    rec_d  = rec_q;
    if (push) begin
      busy_d = 1'b0;
    end
    if (acc) begin
      busy_d      = 1'b1;
      rec_d.pad   = (in_i.pad_char == 8'd0) ? PadSpace : in_i.pad_char;
      rec_d.width = (32'(in_i.width) > MAX_WIDTH) ? 5'(MAX_WIDTH) : in_i.width;
      val_d       = in_i.value;
      cnt_d       = 4'd0;
      if (in_i.kind == KIND_HEX) begin
        rec_d.dig  = {8'd0, in_i.value};
        rec_d.nsig = hex_nsig(in_i.value);
        done_d     = 1'b1;
      end else begin
        done_d = 1'b0;
      end
    end else if (busy_q && !done_q) begin
      rec_d.dig[cnt_q] = rem;
      rec_d.nsig       = cnt_q + 4'd1;
      cnt_d            = cnt_q + 4'd1;
      val_d            = 32'(quo);
      done_d           = (quo == 29'd0);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    val_q <= val_d;
    cnt_q <= cnt_d;
    rec_q <= rec_d;
  end

endmodule

/* src/fwnf_fifo.sv */
module fwnf_fifo import fwnf_pkg::*; #(
  parameter int DEPTH = FifoDepth
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  rec_t                       wr_data_i,
  input  logic                       wr_valid_i,
  output logic                       wr_ready_o,
  output rec_t                       rd_data_o,
  output logic                       rd_valid_o,
  input  logic                       rd_ready_i,
  output logic [$clog2(DEPTH+1)-1:0] count_o
);

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  rec_t          mem_q [DEPTH];
  logic [AW-1:0] wr_q, rd_q;
  logic [CW-1:0] cnt_q;
  logic          push, pop;

  assign wr_ready_o = (cnt_q != CW'(DEPTH));
  assign rd_valid_o = (cnt_q != '0);
  assign rd_data_o  = mem_q[rd_q];
  assign count_o    = cnt_q;
  assign push       = wr_valid_i && wr_ready_o;
  assign pop        = rd_valid_o && rd_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push) begin
        wr_q <= (wr_q == AW'(DEPTH - 1)) ? '0 : wr_q + AW'(1);
      end
      if (pop) begin
        rd_q <= (rd_q == AW'(DEPTH - 1)) ? '0 : rd_q + AW'(1);
      end
      if (push && !pop) begin
        cnt_q <= cnt_q + CW'(1);
      end else if (pop && !push) begin
        cnt_q <= cnt_q - CW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_q] <= wr_data_i;
    end
  end

endmodule

/* src/fwnf_back.sv */
module fwnf_back import fwnf_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  rec_t        rec_i,
  input  logic        rec_valid_i,
  output logic        rec_ready_o,
  fwnf_out_if.source  out_o
);

  logic       have_q, have_d;
  logic [4:0] k_q, k_d;
  rec_t       cur_q, cur_d;
  logic       oval_q, oval_d;
  logic [7:0] ch_q, ch_d;
  logic       last_q, last_d;

  logic       out_ld, emit, is_last, fin, pop;
  logic [4:0] j;
  logic [7:0] chr;

  assign out_ld  = !oval_q || out_o.ready;
  assign emit    = have_q && (cur_q.width != 5'd0) && out_ld;
  assign is_last = (k_q == cur_q.width - 5'd1);
  assign fin     = have_q && ((cur_q.width == 5'd0) || (emit && is_last));
  assign pop     = rec_valid_i && (!have_q || fin);
  assign rec_ready_o = !have_q || fin;

  // Position counted from the right; beyond the significant digits it is padding.
  assign j   = cur_q.width - 5'd1 - k_q;
  assign chr = (j < {1'b0, cur_q.nsig}) ? glyph(cur_q.dig[j[3:0]]) : cur_q.pad;

  assign out_o.valid = oval_q;
  assign out_o.ch    = ch_q;
  assign out_o.last  = last_q;

  always_comb begin
    have_d = have_q;
    k_d    = k_q;
    cur_d  = cur_q;
    oval_d = oval_q;
    ch_d   = ch_q;
    last_d = last_q;
    if (out_ld) begin
      oval_d = emit;
    end
    if (emit) begin
      ch_d   = chr;
      last_d = is_last;
      k_d    = k_q + 5'd1;
    end
    if (pop) begin
      have_d = 1'b1;
      cur_d  = rec_i;
      k_d    = 5'd0;
    end else if (fin) begin
      have_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      have_q <= 1'b0;
      oval_q <= 1'b0;
    end else begin
      have_q <= have_d;
      oval_q <= oval_d;
    end
  end

  always_ff @(posedge clk_i) begin
    k_q    <= k_d;
    cur_q  <= cur_d;
    ch_q   <= ch_d;
    last_q <= last_d;
  end

endmodule

/* src/fixed_width_number_formatter.sv */
// Fixed-width number formatter.
// The in_i channel takes one request per beat: a 32-bit unsigned value, a radix
// kind (decimal or upper-case hex), a field width and a pad character (0 gives a
// space). The out_o channel returns the field one ASCII character per beat, most
// significant first, with last set on the final character; width 0 returns nothing.
// Widths above MAX_WIDTH are clamped.
// The front end converts the number: hex digits are taken as they stand, decimal
// ones (1 to 10 significant digits) come one at a time from a reciprocal multiply by
// ten. A two-entry queue hands the digits to the back end, which emits one character
// per cycle while the receiver is ready, through a registered output stage. The front
// end can take the next request while earlier fields still wait or drain. Sustained
// throughput is set by the output port for wide fields and by the divide-by-ten
// loop for narrow decimal ones.
// Reset clears the queue and all valid flags; nothing is left over from before.
// When the receiver stalls, the current character holds on out_o, the back end
// waits, the queue fills, and then in_i drops ready.
module fixed_width_number_formatter import fwnf_pkg::*; #(
  parameter int MAX_WIDTH  = MaxWidthDef,
  parameter int FIFO_DEPTH = FifoDepth
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  fwnf_in_if.sink    in_i,
  fwnf_out_if.source out_o
);

  localparam int CW = $clog2(FIFO_DEPTH + 1);

  rec_t          f_rec, b_rec;
  logic          f_valid, f_ready, b_valid, b_ready, f_busy;
  logic [CW-1:0] q_count;

  fwnf_front #(.MAX_WIDTH(MAX_WIDTH)) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_i        (in_i),
    .rec_o       (f_rec),
    .rec_valid_o (f_valid),
    .rec_ready_i (f_ready),
    .busy_o      (f_busy)
  );

  fwnf_fifo #(.DEPTH(FIFO_DEPTH)) u_fifo (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wr_data_i  (f_rec),
    .wr_valid_i (f_valid),
    .wr_ready_o (f_ready),
    .rd_data_o  (b_rec),
    .rd_valid_o (b_valid),
    .rd_ready_i (b_ready),
    .count_o    (q_count)
  );

  fwnf_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .rec_i       (b_rec),
    .rec_valid_i (b_valid),
    .rec_ready_o (b_ready),
    .out_o       (out_o)
  );

  a_queue_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(q_count) <= FIFO_DEPTH)
    else $error("queue count exceeds its depth");

  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_i.valid && in_i.ready) |=> f_busy)
    else $error("front end idle after taking a request");

  a_full_blocks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (f_busy && !f_valid) |-> !in_i.ready)
    else $error("front end took a request while still converting");

endmodule

/* bench/fwnf_char_checker.sv */
`timescale 1ns / 1ps

module fwnf_char_checker import fwnf_pkg::*; #(
  parameter int MAX_WIDTH = MaxWidthDef
) (
  input  logic clk_i,
  input  logic rst_ni,
  fwnf_in_if   in_mon,
  fwnf_out_if  out_mon,
  output int   fail_count_o,
  output int   pending_o
);

  typedef struct packed {
    logic [7:0] ch;
    logic       last;
  } field_char_t;

  field_char_t expected_chars[$];
  field_char_t oldest;
  int          mismatches;

  // Builds the characters of one field, most significant first.
  function automatic void format_field(input kind_e kind, input logic [31:0] value,
                                       input logic [4:0] width, input logic [7:0] pad_code);
    logic [3:0]  digits[DecDigits];
    logic [31:0] rest;
    logic [7:0]  pad;
    logic [7:0]  c;
    int          n_sig;
    int          w;
    int          j;
    field_char_t item;
    rest  = value;
    n_sig = 0;
    pad   = (pad_code == 8'd0) ? PadSpace : pad_code;
    w     = (int'(width) > MAX_WIDTH) ? MAX_WIDTH : int'(width);
    if (kind == KIND_DEC) begin
      // A zero value still shows a single digit in decimal.
      do begin
        digits[n_sig] = 4'(rest % 10);
        rest = rest / 10;
        n_sig++;
      end while (rest != 32'd0 && n_sig < DecDigits);
    end else begin
      while (rest != 32'd0 && n_sig < HexDigits) begin
        digits[n_sig] = rest[3:0];
        rest = rest >> 4;
        n_sig++;
      end
    end
    for (int k = 0; k < w; k++) begin
      j = w - 1 - k;
      if (j < n_sig) begin
        if (digits[j] < Radix) begin
          c = CharZero + {4'd0, digits[j]};
        end else begin
          c = CharAlpha + {4'd0, digits[j] - Radix};
        end
      end else begin
        c = pad;
      end
      item.ch   = c;
      item.last = (k == w - 1);
      expected_chars.push_back(item);
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      expected_chars.delete();
      mismatches = 0;
      fail_count_o <= 0;
      pending_o    <= 0;
    end else begin
      if (out_mon.valid && out_mon.ready) begin
        if (expected_chars.size() == 0) begin
          $error("unexpected beat: ch %h last %b", out_mon.ch, out_mon.last);
          mismatches++;
        end else begin
          oldest = expected_chars.pop_front();
          if (out_mon.ch !== oldest.ch) begin
            $error("ch: expected %h, got %h", oldest.ch, out_mon.ch);
            mismatches++;
          end
          if (out_mon.last !== oldest.last) begin
            $error("last: expected %b, got %b", oldest.last, out_mon.last);
            mismatches++;
          end
        end
      end
      if (in_mon.valid && in_mon.ready) begin
        format_field(kind_e'(in_mon.kind), in_mon.value, in_mon.width, in_mon.pad_char);
      end
      fail_count_o <= mismatches;
      pending_o    <= expected_chars.size();
    end
  end

endmodule

/* bench/tb.sv */
`timescale 1ns / 1ps

module tb;
  import fwnf_pkg::*;

  localparam int RandomItems = 91;
  localparam int HoldCycles  = 300;
  localparam int TailCycles  = 40;
  localparam int CycleLimit  = 200000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic hold_off_req = 1'b0;
  int   fail_count;
  int   pending;

  fwnf_in_if  in_bus ();
  fwnf_out_if out_bus ();

  fixed_width_number_formatter dut (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .in_i   (in_bus.sink),
    .out_o  (out_bus.source)
  );

  fwnf_char_checker checker_i (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .in_mon       (in_bus),
    .out_mon      (out_bus),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  always #5 clk = ~clk;

  // Offers one request and returns at the edge where its beat is taken.
  task automatic send_request(input kind_e kind, input logic [31:0] value,
                              input logic [4:0] width, input logic [7:0] pad_char);
    in_bus.valid    <= 1'b1;
    in_bus.kind     <= kind;
    in_bus.value    <= value;
    in_bus.width    <= width;
    in_bus.pad_char <= pad_char;
    do @(posedge clk); while (!in_bus.ready);
  endtask

  task automatic wait_drained();
    in_bus.valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
  endtask

  task automatic send_random_request();
    logic [31:0] value;
    logic [31:0] p;
    logic [4:0]  width;
    logic [7:0]  pad_char;
    kind_e       kind;
    kind = kind_e'($urandom_range(0, 1));
    case ($urandom_range(0, 5))
      0: value = $urandom();
      1: value = $urandom_range(0, 255);
      2: value = 32'd1 << $urandom_range(0, 31);
      3: begin
        p = 32'd1;
        repeat ($urandom_range(0, 9)) p = p * 10;
        value = p - $urandom_range(0, 1);
      end
      4: value = ($urandom_range(0, 1) != 0) ? 32'hffff_ffff : 32'd0;
      default: value = $urandom() >> $urandom_range(0, 31);
    endcase
    if ($urandom_range(0, 9) == 0) begin
      width = 5'($urandom_range(17, 31));
    end else begin
      width = 5'($urandom_range(0, 16));
    end
    pad_char = ($urandom_range(0, 3) == 0) ? 8'd0 : 8'($urandom_range(0, 255));
    send_request(kind, value, width, pad_char);
  endtask

  // Receiver: random stall modes in spans, plus one long hold-off on request.
  initial begin : rx_pattern
    int mode;
    int span;
    mode = 0;
    span = 0;
    out_bus.ready = 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      @(posedge clk);
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        out_bus.ready <= 1'b0;
        repeat (HoldCycles) @(posedge clk);
      end else begin
        if (span == 0) begin
          mode = $urandom_range(0, 3);
          span = $urandom_range(5, 60);
        end
        span--;
        case (mode)
          0: out_bus.ready <= 1'b1;
          1: out_bus.ready <= 1'($urandom_range(0, 1));
          2: out_bus.ready <= ($urandom_range(0, 9) == 0);
          default: out_bus.ready <= ($urandom_range(0, 4) != 0);
        endcase
      end
    end
  end

  initial begin : watchdog
    int unsigned cycles;
    cycles = 0;
    while (cycles < CycleLimit) begin
      @(posedge clk);
      cycles++;
    end
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  initial begin : stimulus
    int burst_left;
    int gap;
    burst_left = 0;
    in_bus.valid    = 1'b0;
    in_bus.kind     = 1'b0;
    in_bus.value    = 32'd0;
    in_bus.width    = 5'd0;
    in_bus.pad_char = 8'd0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed corners: zero in both radices, extremes, clamping, empty fields.
    send_request(KIND_DEC, 32'd0, 5'd1, 8'h00);
    send_request(KIND_HEX, 32'd0, 5'd4, 8'h2a);
    send_request(KIND_DEC, 32'd0, 5'd5, 8'h30);
    send_request(KIND_DEC, 32'hffff_ffff, 5'd10, 8'h30);
    send_request(KIND_HEX, 32'hffff_ffff, 5'd8, 8'h00);
    send_request(KIND_DEC, 32'hffff_ffff, 5'd16, 8'h00);
    send_request(KIND_HEX, 32'hdead_beef, 5'd16, 8'hff);
    send_request(KIND_DEC, 32'd42, 5'd0, 8'h2e);
    send_request(KIND_HEX, 32'h1234_5678, 5'd0, 8'h00);
    send_request(KIND_DEC, 32'd987654321, 5'd17, 8'h01);
    send_request(KIND_HEX, 32'h89ab_cdef, 5'd31, 8'h80);
    send_request(KIND_DEC, 32'd123456, 5'd3, 8'h00);
    send_request(KIND_HEX, 32'h0123_4567, 5'd2, 8'h7f);
    send_request(KIND_DEC, 32'd1, 5'd1, 8'h55);
    send_request(KIND_HEX, 32'ha, 5'd1, 8'haa);
    send_request(KIND_DEC, 32'd1000000000, 5'd10, 8'h00);
    send_request(KIND_HEX, 32'h1000_0000, 5'd8, 8'h00);
    send_request(KIND_HEX, 32'h89ab_cdef, 5'd12, 8'h2d);
    send_request(KIND_DEC, 32'd4294967295, 5'd9, 8'h20);
    wait_drained();

    for (int n = 0; n < RandomItems; n++) begin
      if (n == 40) begin
        // The receiver holds off while beats keep coming, so the block backs up.
        hold_off_req = 1'b1;
        burst_left = 24;
      end
      if (n == 80) begin
        wait_drained();
      end
      if (burst_left == 0) begin
        gap = ($urandom_range(0, 7) == 0) ? $urandom_range(10, 30) : $urandom_range(0, 6);
        if (gap != 0) begin
          in_bus.valid <= 1'b0;
          repeat (gap) @(posedge clk);
        end
        burst_left = $urandom_range(1, 12);
      end
      send_random_request();
      burst_left--;
    end

    wait_drained();
    repeat (TailCycles) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
